[rtl/tkwpl_pkg.sv]
// Shared types and constants of the weighted top-k process list.
// Used by the top level; depends on nothing.
package tkwpl_pkg;

	typedef struct packed {
		logic [15:0] mem;
		logic [15:0] cpu;
		logic [31:0] owner;
		logic [21:0] pid;
	} rec_t;

	localparam int SCORE_W = 18;
	localparam logic [15:0] MIN_MEM_RESET = 16'd500;

	typedef logic [SCORE_W-1:0] score_t;

	// Score is three times the cpu share plus half the memory share, rounded down.
	function automatic score_t score_of(input logic [15:0] cpu, input logic [15:0] mem);
		score_t c;
		c = {2'b00, cpu};
		return (c << 1) + c + {3'b000, mem[15:1]};
	endfunction

endpackage

[rtl/tkwpl_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used by the top level to hold the ranked list.
module tkwpl_ram #(
	parameter int WIDTH = 86,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/top_k_weighted_process_list.sv]
// Top level of the weighted top-k process list.
// Depends on tkwpl_pkg and instantiates tkwpl_ram for the ranked entries.
//
// Usage:
// Process records arrive on the s_ stream, one per transfer; s_tlast marks the
// last record of a round. The memory floor is written over the cfg_ channel and
// resets to 500. A record is ranked by walking the stored list one entry per
// cycle through the RAM, shifting the entries below the insertion point down by
// one as it goes. At the end of a round the list is sent on the m_ stream in
// rank order, each entry being read from the RAM and then loaded into an
// output register, with m_tlast on the final entry; the list is then empty.
// That register holds each result, so a stalled receiver only pauses the
// readout, and the next record is taken as soon as the last entry has been
// loaded into that register.
// Reset empties the list and restores the floor; the RAM needs no clearing.
module top_k_weighted_process_list #(
	parameter int LIST_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,   // min_mem_share
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,    // process_id, owner_id, cpu_share, mem_share, zero pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,    // out_process_id, out_owner_id, out_cpu_share,
	                                // out_mem_share, rank, zero pad
	output logic        m_tlast
);

	localparam int IDX_W = $clog2(LIST_SIZE);
	localparam int CNT_W = $clog2(LIST_SIZE + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_SIZE);
	localparam logic [CNT_W-1:0] CNT_APPEND = CNT_W'(LIST_SIZE - 2);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_WALK    = 5'b00010,
		ST_TAIL    = 5'b00100,
		ST_EMIT_RD = 5'b01000,
		ST_EMIT_LD = 5'b10000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 shift_q;
	logic                 tail_en_q;
	logic                 last_q;
	logic [15:0]          min_mem_q;
	tkwpl_pkg::rec_t      new_q;
	tkwpl_pkg::rec_t      carry_q;
	tkwpl_pkg::score_t    new_score_q;
	tkwpl_pkg::rec_t      out_q;
	logic [3:0]           out_rank_q;
	logic                 out_last_q;
	logic                 out_valid_q;

	tkwpl_pkg::rec_t      s_rec;
	logic                 accept;
	logic                 skip;
	logic                 beat;
	logic                 at_end;
	logic                 out_free;

	logic                 ram_wr_en;
	logic [IDX_W-1:0]     ram_wr_addr;
	tkwpl_pkg::rec_t      ram_wr_data;
	logic                 ram_rd_en;
	logic [IDX_W-1:0]     ram_rd_addr;
	tkwpl_pkg::rec_t      ram_rd_data;

	assign s_rec = tkwpl_pkg::rec_t'(s_tdata[85:0]);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign skip = (s_rec.pid == '0) || ((s_rec.cpu == '0) && (s_rec.mem <= min_mem_q));
	assign beat = tkwpl_pkg::score_of(ram_rd_data.cpu, ram_rd_data.mem) < new_score_q;
	assign at_end = (CNT_W'(idx_q) + 1'b1) == cnt_q;
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b000000, out_rank_q, out_q};
	assign m_tlast = out_last_q;

	always_comb begin
		ram_rd_en = 1'b0;
		ram_rd_addr = idx_q;
		ram_wr_en = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = carry_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !skip && cnt_q != '0) begin
					ram_rd_en = 1'b1;
					ram_rd_addr = '0;
				end
			end
			ST_WALK: begin
				if (shift_q) begin
					ram_wr_en = 1'b1;
				end else if (beat) begin
					ram_wr_en = 1'b1;
					ram_wr_data = new_q;
				end
				if (!at_end) begin
					ram_rd_en = 1'b1;
					ram_rd_addr = idx_q + 1'b1;
				end
			end
			ST_TAIL: begin
				ram_wr_en = tail_en_q;
				ram_wr_addr = IDX_W'(cnt_q);
			end
			ST_EMIT_RD: begin
				ram_rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tkwpl_ram #(
		.WIDTH($bits(tkwpl_pkg::rec_t)),
		.DEPTH(LIST_SIZE)
	) u_list_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			shift_q <= 1'b0;
			tail_en_q <= 1'b0;
			last_q <= 1'b0;
			min_mem_q <= tkwpl_pkg::MIN_MEM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_mem_q <= cfg_data;
			end
			if (state_q == ST_EMIT_LD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						shift_q <= 1'b0;
						last_q <= s_tlast;
						if (skip) begin
							if (s_tlast && cnt_q != '0) begin
								state_q <= ST_EMIT_RD;
							end
						end else if (cnt_q == '0) begin
							tail_en_q <= 1'b1;
							state_q <= ST_TAIL;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (shift_q || beat) begin
						shift_q <= 1'b1;
					end
					if (!at_end) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_TAIL;
						if (shift_q || beat) begin
							tail_en_q <= cnt_q < CNT_FULL;
						end else begin
							tail_en_q <= cnt_q < CNT_APPEND;
						end
					end
				end
				ST_TAIL: begin
					if (tail_en_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					idx_q <= '0;
					state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						if (at_end) begin
							cnt_q <= '0;
							idx_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q <= s_rec;
			carry_q <= s_rec;
			new_score_q <= tkwpl_pkg::score_of(s_rec.cpu, s_rec.mem);
		end else if (state_q == ST_WALK && (shift_q || beat)) begin
			carry_q <= ram_rd_data;
		end
		if (state_q == ST_EMIT_LD && out_free) begin
			out_q <= ram_rd_data;
			out_rank_q <= 4'(idx_q);
			out_last_q <= at_end;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("list count exceeds the list size");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en && ram_wr_addr == ram_rd_addr))
		else $error("RAM read and write hit the same entry");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_EMIT_RD || state_q == ST_EMIT_LD)
		|-> (CNT_W'(idx_q) < cnt_q))
		else $error("walk index beyond stored entries");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD && out_free && at_end) |=> (cnt_q == '0 && m_tlast))
		else $error("list not cleared after its final entry");
`endif

endmodule
